// ----- rtl/core/cll_pkg.sv -----
// Shared types and constants for the circular linked list engine.
// Holds the word structs, the operation and status codes and the sequencer states.
// No dependencies.
package cll_pkg;

  localparam int unsigned POOL_SIZE_DEF = 32;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned COUNT_W       = 6;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT   = 3'd0,
    OP_PUSH_BACK    = 3'd1,
    OP_INSERT_AFTER = 3'd2,
    OP_POP_FRONT    = 3'd3,
    OP_POP_BACK     = 3'd4,
    OP_REMOVE       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_ALLOC_WAIT,
    S_LINK1,
    S_LINK2,
    S_SRCH_START,
    S_SRCH,
    S_UNL_RD,
    S_UNL_CAP,
    S_UNLINK,
    S_FIN_H,
    S_FIN_T,
    S_FIN_B,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0] operation;
    value_t     item_value;
    value_t     anchor_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    count_t     entry_count;
    value_t     front_value;
    value_t     back_value;
  } out_word_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } ctrl_status_t;

endpackage

// ----- rtl/core/circular_linked_list_engine.sv -----
// Circular doubly linked list engine: a node pool of POOL_SIZE signed 32-bit values.
//
// Input channel: in_valid_i, in_stall_o, in_word_i. A word carries an operation
// (push front, push back, insert after anchor, pop front, pop back, remove value)
// and its operands. A word is taken when in_valid_i is high and in_stall_o is low.
// Output channel: out_valid_o, out_stall_i, out_word_o. Every input word produces
// exactly one result word: a status, the entry count and the front and back values.
//
// The block works on one word at a time and holds in_stall_o high meanwhile.
// Insert-after and remove walk the list one link per clock through the registered
// read port of the link memory, starting at the head; a missed search passes every
// node of the list before it reports. The result sits in an output register, and
// the sequencer goes idle as it loads, so the next word can be accepted even while
// that result still waits; if out_stall_i stays high, the following result waits in
// the sequencer and the input stays stalled until it frees.
// Reset empties the list at once; there is no clearing pass, since free nodes are
// tracked by a fill count of never-used nodes plus a stack of released nodes.
// Uses cll_pkg, cll_ctrl and cll_ram.
module circular_linked_list_engine #(
  parameter int unsigned POOL_SIZE = cll_pkg::POOL_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cll_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cll_pkg::out_word_t out_word_o
);

  cll_pkg::ctrl_status_t ctrl_stat;
  cll_pkg::out_word_t    res_word;
  logic                  in_take, res_ready, res_load;
  logic                  out_valid_q, out_valid_d;
  cll_pkg::out_word_t    out_word_q;

  // The sequencer takes a new word only when it has nothing in flight.
  assign in_stall_o = !ctrl_stat.idle;
  assign in_take    = in_valid_i && !in_stall_o;

  // The output register is free when empty or being emptied this cycle.
  assign res_ready = !out_valid_q || !out_stall_i;
  assign res_load  = ctrl_stat.res_valid && res_ready;

  cll_ctrl #(.POOL_SIZE(POOL_SIZE)) u_ctrl (
    .clk_i,
    .rst_ni,
    .take_i      (in_take),
    .word_i      (in_word_i),
    .res_ready_i (res_ready),
    .stat_o      (ctrl_stat),
    .res_o       (res_word)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef ASSERT_OFF
  // A result can only be offered while a word is being worked on.
  a_res_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_stat.res_valid |-> !ctrl_stat.idle)
    else $error("result offered while sequencer idle");

  // A freshly accepted word never yields its result on the following edge.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> !res_load)
    else $error("result loaded right after acceptance");

  // An empty-list status always reports an empty list.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status == cll_pkg::ST_EMPTY)) |->
    ((out_word_o.entry_count == '0) && (out_word_o.front_value == '0) &&
     (out_word_o.back_value == '0)))
    else $error("empty status with nonzero count or values");

  // While the output is stalled the held result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled result changed");
`endif

endmodule

// ----- rtl/core/cll_ram.sv -----
// Simple dual-port memory: one write port, one read port with registered data.
// Used for node values, both link arrays and the free-node stack. Uses cll_pkg.
module cll_ram #(
  parameter int unsigned WIDTH = cll_pkg::VALUE_W,
  parameter int unsigned DEPTH = cll_pkg::POOL_SIZE_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/cll_ctrl.sv -----
// Sequencer and datapath of the linked list engine: decodes one word, walks the
// list one link per cycle with a shared value compare, and rewrites links.
// Uses cll_pkg and cll_ram.
module cll_ctrl #(
  parameter int unsigned POOL_SIZE = cll_pkg::POOL_SIZE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  cll_pkg::in_word_t    word_i,
  input  logic                 res_ready_i,
  output cll_pkg::ctrl_status_t stat_o,
  output cll_pkg::out_word_t   res_o
);

  localparam int unsigned AW = $clog2(POOL_SIZE);
  localparam int unsigned LW = $clog2(POOL_SIZE + 1);

  cll_pkg::state_e  state_q, state_d;
  logic [2:0]       op_q, op_d;
  cll_pkg::value_t  item_q, item_d;
  cll_pkg::value_t  target_q, target_d;
  cll_pkg::status_e status_q, status_d;
  logic [AW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [LW-1:0]    len_q, len_d, fresh_q, fresh_d, sp_q, sp_d, k_q, k_d;
  logic [AW-1:0]    cur_q, cur_d, n_q, n_d, p_q, p_d, x_q, x_d;
  cll_pkg::value_t  front_q, front_d, back_q, back_d;

  logic                val_we, nxt_we, prv_we, stk_we;
  logic [AW-1:0]       val_waddr, nxt_waddr, prv_waddr, stk_waddr;
  logic [AW-1:0]       val_raddr, nxt_raddr, prv_raddr, stk_raddr;
  logic [AW-1:0]       nxt_wdata, prv_wdata;
  logic [AW-1:0]       nxt_rdata, prv_rdata, stk_rdata;
  cll_pkg::value_t     val_rdata;

  logic          len_zero, len_full, is_match, last_node, is_push;
  logic [LW-1:0] sp_m1, k_p1;

  assign len_zero  = (len_q == '0);
  assign len_full  = (len_q == LW'(POOL_SIZE));
  assign is_match  = (val_rdata == target_q);
  assign k_p1      = k_q + LW'(1);
  assign last_node = (k_p1 == len_q);
  assign sp_m1     = sp_q - LW'(1);
  assign is_push   = (op_q == cll_pkg::OP_PUSH_FRONT) || (op_q == cll_pkg::OP_PUSH_BACK);

  cll_ram #(.WIDTH(cll_pkg::VALUE_W), .DEPTH(POOL_SIZE)) u_val (
    .clk_i, .we_i(val_we), .waddr_i(val_waddr), .wdata_i(item_q),
    .raddr_i(val_raddr), .rdata_o(val_rdata)
  );
  cll_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_nxt (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .raddr_i(nxt_raddr), .rdata_o(nxt_rdata)
  );
  cll_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_prv (
    .clk_i, .we_i(prv_we), .waddr_i(prv_waddr), .wdata_i(prv_wdata),
    .raddr_i(prv_raddr), .rdata_o(prv_rdata)
  );
  cll_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(n_q),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cll_pkg::S_IDLE: begin
        if (take_i) state_d = cll_pkg::S_DECODE;
      end
      cll_pkg::S_DECODE: begin
        case (op_q)
          cll_pkg::OP_PUSH_FRONT, cll_pkg::OP_PUSH_BACK: begin
            state_d = len_full ? cll_pkg::S_FIN_H : cll_pkg::S_ALLOC;
          end
          cll_pkg::OP_INSERT_AFTER: begin
            state_d = (len_zero || len_full) ? cll_pkg::S_FIN_H : cll_pkg::S_SRCH_START;
          end
          cll_pkg::OP_POP_FRONT, cll_pkg::OP_POP_BACK: begin
            state_d = len_zero ? cll_pkg::S_FIN_H : cll_pkg::S_UNL_RD;
          end
          cll_pkg::OP_REMOVE: begin
            state_d = len_zero ? cll_pkg::S_FIN_H : cll_pkg::S_SRCH_START;
          end
          default: state_d = cll_pkg::S_FIN_H;
        endcase
      end
      cll_pkg::S_ALLOC: begin
        state_d = (sp_q != '0) ? cll_pkg::S_ALLOC_WAIT : cll_pkg::S_LINK1;
      end
      cll_pkg::S_ALLOC_WAIT: state_d = cll_pkg::S_LINK1;
      cll_pkg::S_LINK1: begin
        state_d = len_zero ? cll_pkg::S_FIN_H : cll_pkg::S_LINK2;
      end
      cll_pkg::S_LINK2: state_d = cll_pkg::S_FIN_H;
      cll_pkg::S_SRCH_START: state_d = cll_pkg::S_SRCH;
      cll_pkg::S_SRCH: begin
        if (is_match) begin
          state_d = (op_q == cll_pkg::OP_INSERT_AFTER) ? cll_pkg::S_ALLOC : cll_pkg::S_UNLINK;
        end else if (last_node) begin
          state_d = cll_pkg::S_FIN_H;
        end
      end
      cll_pkg::S_UNL_RD:  state_d = cll_pkg::S_UNL_CAP;
      cll_pkg::S_UNL_CAP: state_d = cll_pkg::S_UNLINK;
      cll_pkg::S_UNLINK:  state_d = cll_pkg::S_FIN_H;
      cll_pkg::S_FIN_H:   state_d = cll_pkg::S_FIN_T;
      cll_pkg::S_FIN_T:   state_d = cll_pkg::S_FIN_B;
      cll_pkg::S_FIN_B:   state_d = cll_pkg::S_DONE;
      cll_pkg::S_DONE: begin
        if (res_ready_i) state_d = cll_pkg::S_IDLE;
      end
      default: state_d = cll_pkg::S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    val_we    = 1'b0;
    nxt_we    = 1'b0;
    prv_we    = 1'b0;
    stk_we    = 1'b0;
    val_waddr = n_q;
    nxt_waddr = n_q;
    prv_waddr = n_q;
    stk_waddr = sp_q[AW-1:0];
    nxt_wdata = x_q;
    prv_wdata = p_q;
    val_raddr = cur_q;
    nxt_raddr = cur_q;
    prv_raddr = cur_q;
    stk_raddr = sp_m1[AW-1:0];
    case (state_q)
      cll_pkg::S_LINK1: begin
        val_we = 1'b1;
        nxt_we = 1'b1;
        prv_we = 1'b1;
        if (len_zero) begin
          // A lone node links to itself in both directions.
          nxt_wdata = n_q;
          prv_wdata = n_q;
        end
      end
      cll_pkg::S_LINK2: begin
        nxt_we    = 1'b1;
        nxt_waddr = p_q;
        nxt_wdata = n_q;
        prv_we    = 1'b1;
        prv_waddr = x_q;
        prv_wdata = n_q;
      end
      cll_pkg::S_SRCH_START: begin
        val_raddr = head_q;
        nxt_raddr = head_q;
        prv_raddr = head_q;
      end
      cll_pkg::S_SRCH: begin
        val_raddr = nxt_rdata;
        nxt_raddr = nxt_rdata;
        prv_raddr = nxt_rdata;
      end
      cll_pkg::S_UNL_RD: begin
        nxt_raddr = n_q;
        prv_raddr = n_q;
      end
      cll_pkg::S_UNLINK: begin
        stk_we = 1'b1;
        if (!(len_q <= LW'(1))) begin
          nxt_we    = 1'b1;
          nxt_waddr = p_q;
          nxt_wdata = x_q;
          prv_we    = 1'b1;
          prv_waddr = x_q;
          prv_wdata = p_q;
        end
      end
      cll_pkg::S_FIN_H: val_raddr = head_q;
      cll_pkg::S_FIN_T: val_raddr = tail_q;
      default: ;
    endcase
  end

  // Datapath register updates.
  always_comb begin
    op_d     = op_q;
    item_d   = item_q;
    target_d = target_q;
    status_d = status_q;
    head_d   = head_q;
    tail_d   = tail_q;
    len_d    = len_q;
    fresh_d  = fresh_q;
    sp_d     = sp_q;
    k_d      = k_q;
    cur_d    = cur_q;
    n_d      = n_q;
    p_d      = p_q;
    x_d      = x_q;
    front_d  = front_q;
    back_d   = back_q;
    case (state_q)
      cll_pkg::S_IDLE: begin
        if (take_i) begin
          op_d     = word_i.operation;
          item_d   = word_i.item_value;
          target_d = (word_i.operation == cll_pkg::OP_INSERT_AFTER) ?
                     word_i.anchor_value : word_i.item_value;
        end
      end
      cll_pkg::S_DECODE: begin
        status_d = cll_pkg::ST_OK;
        p_d      = tail_q;
        x_d      = head_q;
        case (op_q)
          cll_pkg::OP_PUSH_FRONT, cll_pkg::OP_PUSH_BACK: begin
            if (len_full) status_d = cll_pkg::ST_FULL;
          end
          cll_pkg::OP_INSERT_AFTER: begin
            if (len_zero) status_d = cll_pkg::ST_EMPTY;
            else if (len_full) status_d = cll_pkg::ST_FULL;
          end
          cll_pkg::OP_POP_FRONT, cll_pkg::OP_POP_BACK: begin
            if (len_zero) status_d = cll_pkg::ST_EMPTY;
            n_d = (op_q == cll_pkg::OP_POP_FRONT) ? head_q : tail_q;
          end
          cll_pkg::OP_REMOVE: begin
            if (len_zero) status_d = cll_pkg::ST_EMPTY;
          end
          default: ;
        endcase
      end
      cll_pkg::S_ALLOC: begin
        // Recycle a freed node first, otherwise take a never-used one.
        if (sp_q != '0) begin
          sp_d = sp_m1;
        end else begin
          n_d     = fresh_q[AW-1:0];
          fresh_d = fresh_q + LW'(1);
        end
      end
      cll_pkg::S_ALLOC_WAIT: n_d = stk_rdata;
      cll_pkg::S_LINK1: begin
        if (len_zero) begin
          head_d = n_q;
          tail_d = n_q;
          len_d  = LW'(1);
        end
      end
      cll_pkg::S_LINK2: begin
        len_d = len_q + LW'(1);
        if (op_q == cll_pkg::OP_PUSH_FRONT) head_d = n_q;
        if (op_q == cll_pkg::OP_PUSH_BACK) tail_d = n_q;
        if (!is_push && (p_q == tail_q)) tail_d = n_q;
      end
      cll_pkg::S_SRCH_START: begin
        cur_d = head_q;
        k_d   = '0;
      end
      cll_pkg::S_SRCH: begin
        if (is_match) begin
          n_d = cur_q;
          p_d = (op_q == cll_pkg::OP_INSERT_AFTER) ? cur_q : prv_rdata;
          x_d = nxt_rdata;
        end else if (last_node) begin
          status_d = cll_pkg::ST_NOT_FOUND;
        end else begin
          cur_d = nxt_rdata;
          k_d   = k_p1;
        end
      end
      cll_pkg::S_UNL_CAP: begin
        p_d = prv_rdata;
        x_d = nxt_rdata;
      end
      cll_pkg::S_UNLINK: begin
        sp_d = sp_q + LW'(1);
        if (len_q <= LW'(1)) begin
          head_d = '0;
          tail_d = '0;
          len_d  = '0;
        end else begin
          if (n_q == head_q) head_d = x_q;
          if (n_q == tail_q) tail_d = p_q;
          len_d = len_q - LW'(1);
        end
      end
      cll_pkg::S_FIN_T: front_d = val_rdata;
      cll_pkg::S_FIN_B: back_d  = val_rdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cll_pkg::S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      len_q   <= '0;
      fresh_q <= '0;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      len_q   <= len_d;
      fresh_q <= fresh_d;
      sp_q    <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    item_q   <= item_d;
    target_q <= target_d;
    status_q <= status_d;
    k_q      <= k_d;
    cur_q    <= cur_d;
    n_q      <= n_d;
    p_q      <= p_d;
    x_q      <= x_d;
    front_q  <= front_d;
    back_q   <= back_d;
  end

  assign stat_o.idle      = (state_q == cll_pkg::S_IDLE);
  assign stat_o.res_valid = (state_q == cll_pkg::S_DONE);

  assign res_o.status      = status_q;
  assign res_o.entry_count = cll_pkg::count_t'(len_q);
  assign res_o.front_value = len_zero ? '0 : front_q;
  assign res_o.back_value  = len_zero ? '0 : back_q;

endmodule
